### src/q31sa_pkg.sv
// Shared types, constants and helper functions for the Q31 saturating ALU.
`timescale 1ns / 1ps
`default_nettype none

package q31sa_pkg;

  localparam int unsigned Q31_W  = 32;
  localparam int unsigned PROD_W = 2 * Q31_W;

  localparam logic signed [Q31_W-1:0] Q31_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q31_W-1:0] Q31_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_MAC  = 4'd3,
    CMD_MSUB = 4'd4,
    CMD_ABS  = 4'd5,
    CMD_DIV  = 4'd6,
    CMD_SHL  = 4'd7,
    CMD_SHR  = 4'd8
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_MRND = 6'b000100,
    ST_DMUL = 6'b001000,
    ST_DCMP = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  // Clamp a 33-bit sum to the Q31 range.
  function automatic logic signed [Q31_W-1:0] sat33(input logic signed [Q31_W:0] v);
    logic signed [Q31_W-1:0] r;
    if (v[Q31_W] != v[Q31_W-1]) begin
      r = v[Q31_W] ? Q31_MIN : Q31_MAX;
    end else begin
      r = v[Q31_W-1:0];
    end
    return r;
  endfunction

  // Round a raw product to Q31: floor((2*p + 2^31) / 2^32).
  function automatic logic signed [Q31_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    return p[PROD_W-2:Q31_W-1] + {{(Q31_W-1){1'b0}}, p[Q31_W-2]};
  endfunction

endpackage

`default_nettype wire

### src/q31_saturating_alu.sv
// Top level of the Q31 saturating ALU: command sequencer around one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        slave      in_valid_i / in_stall_o   cmd_i, operand_a_i, operand_b_i,
//                                                operand_c_i, shift_amount_i
// out       master     out_valid_o / out_stall_i result_o
//
// One input beat is worked at a time; in_stall_o is high from acceptance until the
// result has moved into the output register. Add, subtract, abs and shifts go
// through the execute and done states; mul/mac/msub add the multiplier register,
// then rounding. Divide bisects through the shared multiplier, a multiply state and
// a compare state per step, at most 31 steps. A held result in the output register
// does not block the next input beat. Reset clears the sequencer and the output valid.

module q31_saturating_alu (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [3:0]                          cmd_i,
  input  wire logic signed [q31sa_pkg::Q31_W-1:0]  operand_a_i,
  input  wire logic signed [q31sa_pkg::Q31_W-1:0]  operand_b_i,
  input  wire logic signed [q31sa_pkg::Q31_W-1:0]  operand_c_i,
  input  wire logic [5:0]                          shift_amount_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [q31sa_pkg::Q31_W-1:0]       result_o
);

  localparam int unsigned W  = q31sa_pkg::Q31_W;
  localparam int unsigned MW = W - 1;  // magnitude width

  // Attach the quotient sign to a magnitude.
  function automatic logic signed [W-1:0] apply_sign(input logic neg,
                                                     input logic [MW-1:0] mag);
    logic signed [W-1:0] m;
    m = {1'b0, mag};
    return neg ? -m : m;
  endfunction

  // Sequencer and output slot
  q31sa_pkg::state_e state_d, state_q;
  logic              out_valid_d, out_valid_q;
  logic signed [W-1:0] out_result_d, out_result_q;

  // Latched command and operands
  q31sa_pkg::cmd_e   cmd_d, cmd_q;
  logic signed [W-1:0] a_d, a_q, b_d, b_q, c_d, c_q;
  logic [5:0]        n_d, n_q;
  logic signed [W-1:0] res_d, res_q;

  // Divide search state
  logic [MW-1:0]     x_d, x_q, y_d, y_q;
  logic [MW-1:0]     lo_d, lo_q, hi_d, hi_q, mid_d, mid_q;
  logic              neg_d, neg_q;

  // Shared multiplier
  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] prod;

  assign mul_a = (state_q == q31sa_pkg::ST_DMUL) ? $signed({1'b0, mid_q}) : a_q;
  assign mul_b = (state_q == q31sa_pkg::ST_DMUL) ? $signed({1'b0, y_q}) : b_q;

  q31sa_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Combinational command datapath
  logic signed [W:0]     sum33, diff33;
  logic signed [W-1:0]   a_abs, b_abs;
  logic signed [W-1:0]   sat_sign;
  logic signed [2*W-2:0] shl_wide;
  logic                  shl_ovf;
  logic signed [W-1:0]   shl_res, shr_res;
  logic                  div_neg;

  assign sum33    = {a_q[W-1], a_q} + {b_q[W-1], b_q};
  assign diff33   = {a_q[W-1], a_q} - {b_q[W-1], b_q};
  assign a_abs    = (a_q == q31sa_pkg::Q31_MIN) ? q31sa_pkg::Q31_MAX :
                    (a_q[W-1] ? -a_q : a_q);
  assign b_abs    = (b_q == q31sa_pkg::Q31_MIN) ? q31sa_pkg::Q31_MAX :
                    (b_q[W-1] ? -b_q : b_q);
  assign sat_sign = a_q[W-1] ? q31sa_pkg::Q31_MIN : q31sa_pkg::Q31_MAX;

  // Left shift saturates on the true value: every bit above the Q31 window
  // must match the sign bit.
  assign shl_wide = {{(W-1){a_q[W-1]}}, a_q} <<< n_q[4:0];
  assign shl_ovf  = !((&shl_wide[2*W-2:W-1]) || !(|shl_wide[2*W-2:W-1]));
  always_comb begin
    if (a_q == '0) begin
      shl_res = '0;
    end else if (n_q[5] || shl_ovf) begin
      shl_res = sat_sign;
    end else begin
      shl_res = shl_wide[W-1:0];
    end
  end

  // Arithmetic right shift; 32 or more gives zero even for negative values.
  always_comb begin
    if (n_q[5]) begin
      shr_res = '0;
    end else begin
      shr_res = a_q >>> n_q[4:0];
    end
  end

  // Zero counts as neither sign.
  assign div_neg = (a_q[W-1] && (b_q != '0) && !b_q[W-1]) ||
                   (!a_q[W-1] && (a_q != '0) && b_q[W-1]);

  // Rounded product and divide compare
  logic signed [W-1:0] qm, mac_res, msub_res;
  logic [W-1:0]        qm_u, x_ext;
  logic [MW-1:0]       up_span, dn_span;

  always_comb begin
    if ((a_q == q31sa_pkg::Q31_MIN) && (b_q == q31sa_pkg::Q31_MIN)) begin
      qm = q31sa_pkg::Q31_MAX;
    end else begin
      qm = q31sa_pkg::q_round(prod);
    end
  end

  assign mac_res  = q31sa_pkg::sat33({qm[W-1], qm} + {c_q[W-1], c_q});
  assign msub_res = q31sa_pkg::sat33({qm[W-1], qm} - {c_q[W-1], c_q});

  // In divide both factors are nonnegative and below 2^31, so no min*min case.
  assign qm_u    = q31sa_pkg::q_round(prod);
  assign x_ext   = {1'b0, x_q};
  assign up_span = hi_q - mid_q;
  assign dn_span = mid_q - lo_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    out_result_d = out_result_q;
    cmd_d        = cmd_q;
    a_d          = a_q;
    b_d          = b_q;
    c_d          = c_q;
    n_d          = n_q;
    res_d        = res_q;
    x_d          = x_q;
    y_d          = y_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    neg_d        = neg_q;

    // Drop the output beat once taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      q31sa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = q31sa_pkg::cmd_e'(cmd_i);
          a_d     = operand_a_i;
          b_d     = operand_b_i;
          c_d     = operand_c_i;
          n_d     = shift_amount_i;
          state_d = q31sa_pkg::ST_EXEC;
        end
      end

      q31sa_pkg::ST_EXEC: begin
        state_d = q31sa_pkg::ST_DONE;
        case (cmd_q) inside
          q31sa_pkg::CMD_ADD: res_d = q31sa_pkg::sat33(sum33);
          q31sa_pkg::CMD_SUB: res_d = q31sa_pkg::sat33(diff33);
          q31sa_pkg::CMD_MUL, q31sa_pkg::CMD_MAC, q31sa_pkg::CMD_MSUB: begin
            // Product of a and b lands in the multiplier register now.
            state_d = q31sa_pkg::ST_MRND;
          end
          q31sa_pkg::CMD_ABS: res_d = a_abs;
          q31sa_pkg::CMD_DIV: begin
            x_d   = a_abs[MW-1:0];
            y_d   = b_abs[MW-1:0];
            neg_d = div_neg;
            if (b_abs == '0) begin
              res_d = q31sa_pkg::Q31_MAX;
            end else if (a_abs >= b_abs) begin
              res_d = div_neg ? q31sa_pkg::Q31_MIN : q31sa_pkg::Q31_MAX;
            end else if (a_abs == '0) begin
              res_d = '0;
            end else begin
              // Bisect over [0, max]; first midpoint is max/2.
              lo_d    = '0;
              hi_d    = {MW{1'b1}};
              mid_d   = {1'b0, {(MW-1){1'b1}}};
              state_d = q31sa_pkg::ST_DMUL;
            end
          end
          q31sa_pkg::CMD_SHL: res_d = shl_res;
          q31sa_pkg::CMD_SHR: res_d = shr_res;
          default:            res_d = '0;
        endcase
      end

      q31sa_pkg::ST_MRND: begin
        state_d = q31sa_pkg::ST_DONE;
        case (cmd_q)
          q31sa_pkg::CMD_MAC:  res_d = mac_res;
          q31sa_pkg::CMD_MSUB: res_d = msub_res;
          default:             res_d = qm;
        endcase
      end

      q31sa_pkg::ST_DMUL: begin
        // Multiplier register takes mid * |b|.
        state_d = q31sa_pkg::ST_DCMP;
      end

      q31sa_pkg::ST_DCMP: begin
        if (qm_u == x_ext) begin
          res_d   = apply_sign(neg_q, mid_q);
          state_d = q31sa_pkg::ST_DONE;
        end else if (qm_u < x_ext) begin
          lo_d = mid_q;
          if (up_span > {{(MW-1){1'b0}}, 1'b1}) begin
            mid_d   = mid_q + (up_span >> 1);
            state_d = q31sa_pkg::ST_DMUL;
          end else begin
            res_d   = apply_sign(neg_q, mid_q);
            state_d = q31sa_pkg::ST_DONE;
          end
        end else begin
          hi_d = mid_q;
          if (dn_span > {{(MW-1){1'b0}}, 1'b1}) begin
            mid_d   = lo_q + (dn_span >> 1);
            state_d = q31sa_pkg::ST_DMUL;
          end else begin
            res_d   = apply_sign(neg_q, lo_q);
            state_d = q31sa_pkg::ST_DONE;
          end
        end
      end

      q31sa_pkg::ST_DONE: begin
        // Hold until the output slot is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_result_d = res_q;
          state_d      = q31sa_pkg::ST_IDLE;
        end
      end

      default: state_d = q31sa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= q31sa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_result_q <= out_result_d;
    cmd_q        <= cmd_d;
    a_q          <= a_d;
    b_q          <= b_d;
    c_q          <= c_d;
    n_q          <= n_d;
    res_q        <= res_d;
    x_q          <= x_d;
    y_q          <= y_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    neg_q        <= neg_d;
  end

  assign in_stall_o  = (state_q != q31sa_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_result_q;

endmodule

`default_nettype wire

### src/q31sa_mul.sv
// Registered signed 32x32 multiplier shared by multiply and divide.
`timescale 1ns / 1ps
`default_nettype none

module q31sa_mul (
  input  wire logic                                   clk_i,
  input  wire logic signed [q31sa_pkg::Q31_W-1:0]     a_i,
  input  wire logic signed [q31sa_pkg::Q31_W-1:0]     b_i,
  output logic signed [q31sa_pkg::PROD_W-1:0]         prod_o
);

  logic signed [q31sa_pkg::PROD_W-1:0] prod_d;
  logic signed [q31sa_pkg::PROD_W-1:0] prod_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### sim/tb_q31_saturating_alu.sv
// Self-checking testbench for the Q31 saturating ALU: directed corners, then random beats.
`timescale 1ns / 1ps

module tb_q31_saturating_alu;

  import q31sa_pkg::*;

  // Codes outside the defined command set; the block must answer them with zero.
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  localparam longint SAT_HI   = longint'(Q31_MAX);
  localparam longint SAT_LO   = longint'(Q31_MIN);
  localparam longint HALF_LSB = longint'(1) <<< 31;

  localparam int MAX_WAIT       = 14;    // longest gap or stall drawn per beat
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES   = 100;   // settle time after the last result is checked
  localparam int MAX_REPORTS    = 10;

  logic                     clk_i = 1'b0;
  logic                     rst_n = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [3:0]               cmd = CMD_ADD;
  logic signed [Q31_W-1:0]  op_a = '0;
  logic signed [Q31_W-1:0]  op_b = '0;
  logic signed [Q31_W-1:0]  op_c = '0;
  logic [5:0]               shift_n = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [Q31_W-1:0]  result;

  // Results predicted for accepted input beats, oldest first.
  logic signed [Q31_W-1:0]  expected_results[$];
  logic signed [Q31_W-1:0]  want;

  bit  idle_off = 1'b0;        // set: neither side inserts gaps or stalls
  int  beats_sent = 0;
  int  results_checked = 0;
  int  fail_count = 0;
  int  stall_drawn_for = -1;   // result index the current output stall was drawn for
  int  stall_left = 0;
  int  stuck_cycles = 0;

  q31_saturating_alu u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .operand_a_i    (op_a),
    .operand_b_i    (op_b),
    .operand_c_i    (op_c),
    .shift_amount_i (shift_n),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_o       (result)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint sat_q31(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Rounded Q31 product: floor((2*x*y + 2^31) / 2^32); min times min clamps to max.
  function automatic longint mul_q31(input longint x, input longint y);
    longint p;
    if (x == SAT_LO && y == SAT_LO) return SAT_HI;
    p = x * y * 2 + HALF_LSB;
    return p >>> 32;
  endfunction

  function automatic logic signed [Q31_W-1:0] predict_alu(
    input logic [3:0] op, input logic signed [Q31_W-1:0] a, input logic signed [Q31_W-1:0] b,
    input logic signed [Q31_W-1:0] c, input logic [5:0] n);
    longint x, y, z, r, mag_a, mag_b, lo, hi, mid, prod;
    bit     neg, found;
    x = longint'(a);
    y = longint'(b);
    z = longint'(c);
    r = 0;
    case (op)
      CMD_ADD:  r = sat_q31(x + y);
      CMD_SUB:  r = sat_q31(x - y);
      CMD_MUL:  r = mul_q31(x, y);
      CMD_MAC:  r = sat_q31(mul_q31(x, y) + z);
      CMD_MSUB: r = sat_q31(mul_q31(x, y) - z);
      CMD_ABS:  r = sat_q31(x < 0 ? -x : x);
      CMD_DIV: begin
        // Zero counts as neither sign.
        neg   = (x < 0 && y > 0) || (x > 0 && y < 0);
        mag_a = sat_q31(x < 0 ? -x : x);
        mag_b = sat_q31(y < 0 ? -y : y);
        if (mag_b == 0) begin
          r = SAT_HI;
        end else if (mag_a >= mag_b) begin
          r = neg ? SAT_LO : SAT_HI;
        end else if (mag_a == 0) begin
          r = 0;
        end else begin
          // Bisect on the quotient magnitude; stop early on an exact product.
          lo    = 0;
          hi    = SAT_HI;
          found = 1'b0;
          while (hi - lo > 1 && !found) begin
            mid  = lo + ((hi - lo) >>> 1);
            prod = mul_q31(mid, mag_b);
            if (prod == mag_a) begin
              lo    = mid;
              found = 1'b1;
            end else if (prod < mag_a) begin
              lo = mid;
            end else begin
              hi = mid;
            end
          end
          r = neg ? -lo : lo;
        end
      end
      CMD_SHL: begin
        if (x == 0) r = 0;
        else if (n > 31) r = (x > 0) ? SAT_HI : SAT_LO;
        else r = sat_q31(x * (longint'(1) <<< n));
      end
      CMD_SHR: r = (n > 31) ? 0 : (x >>> n);
      default: r = 0;
    endcase
    return r[Q31_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Operand mix: near the rails, tiny values, single powers of two, or anything.
  function automatic logic signed [Q31_W-1:0] rand_q31();
    logic signed [Q31_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = Q31_MAX - $urandom_range(0, 3);
      1:       v = Q31_MIN + $urandom_range(0, 3);
      2:       v = $urandom_range(0, 255) - 128;
      3: begin
        v = 32'sd1 <<< $urandom_range(0, 30);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [5:0] rand_shift();
    return $urandom_range(0, 1) ? 6'($urandom_range(0, 33)) : 6'($urandom_range(0, 63));
  endfunction

  // Drive one input beat at the falling edge and hold it until it is taken.
  task automatic send_beat(input logic [3:0] c_cmd, input logic signed [Q31_W-1:0] a,
                           input logic signed [Q31_W-1:0] b,
                           input logic signed [Q31_W-1:0] c, input logic [5:0] n);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd      = c_cmd;
    op_a     = a;
    op_b     = b;
    op_c     = c;
    shift_n  = n;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    expected_results.push_back(predict_alu(c_cmd, a, b, c, n));
    beats_sent++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall and check
  // ---------------------------------------------------------------------------

  // Draw a fresh stall length once per waiting result, then release.
  always @(negedge clk_i) begin
    if (out_valid && stall_drawn_for != results_checked) begin
      stall_left      = idle_off ? 0 : $urandom_range(0, MAX_WAIT);
      stall_drawn_for = results_checked;
    end
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic note_failure(input string what, input logic signed [Q31_W-1:0] exp_v,
                              input logic signed [Q31_W-1:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    end
  endtask

  // Compare every output beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure("result beat with nothing pending", 'x, result);
      end else begin
        want = expected_results.pop_front();
        if (result !== want) note_failure("result mismatch", want, result);
      end
      results_checked++;
    end
  end

  // Give up when no beat moves on either channel for too long.
  initial begin : watchdog
    wait (rst_n);
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("[%0t] timeout: no beat for %0d cycles, %0d results pending", $realtime,
             WATCHDOG_LIMIT, expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_add_sub();
    send_beat(CMD_ADD, Q31_MAX, 32'sd1, $urandom(), rand_shift());   // clamps high
    send_beat(CMD_ADD, Q31_MIN, -32'sd1, $urandom(), rand_shift());  // clamps low
    send_beat(CMD_SUB, Q31_MIN, 32'sd1, $urandom(), rand_shift());
  endtask

  task automatic test_multiply();
    send_beat(CMD_MUL, Q31_MIN, Q31_MIN, $urandom(), rand_shift());  // min times min
    send_beat(CMD_MUL, 32'sh4000_0000, 32'sh4000_0000, $urandom(), rand_shift());
    send_beat(CMD_MUL, -32'sd1, 32'sd1, $urandom(), rand_shift());   // rounds to zero
    // Min times min is already max before the accumulator joins in.
    send_beat(CMD_MAC, Q31_MIN, Q31_MIN, 32'sd1, rand_shift());
    send_beat(CMD_MSUB, Q31_MIN, Q31_MIN, Q31_MAX, rand_shift());
  endtask

  task automatic test_abs();
    send_beat(CMD_ABS, Q31_MIN, $urandom(), $urandom(), rand_shift());
    send_beat(CMD_ABS, -32'sd1, $urandom(), $urandom(), rand_shift());
  endtask

  task automatic test_divide();
    send_beat(CMD_DIV, 32'sd12345, 32'sd0, $urandom(), rand_shift());   // by zero
    send_beat(CMD_DIV, Q31_MIN, Q31_MAX, $urandom(), rand_shift());     // too big, negative
    send_beat(CMD_DIV, 32'sd0, -32'sd7, $urandom(), rand_shift());      // zero dividend
    // Quarter over half: the very first midpoint is an exact match.
    send_beat(CMD_DIV, 32'sh2000_0000, 32'sh4000_0000, $urandom(), rand_shift());
    send_beat(CMD_DIV, -32'sh2000_0000, 32'sh4000_0000, $urandom(), rand_shift());
  endtask

  task automatic test_shifts();
    send_beat(CMD_SHL, 32'sd0, $urandom(), $urandom(), 6'd63);
    send_beat(CMD_SHL, 32'sd1, $urandom(), $urandom(), 6'd31);     // one past max
    send_beat(CMD_SHL, -32'sd1, $urandom(), $urandom(), 6'd31);    // lands on min
    send_beat(CMD_SHL, -32'sd5, $urandom(), $urandom(), 6'd40);
    send_beat(CMD_SHR, -32'sd1, $urandom(), $urandom(), 6'd63);    // zero, not -1
    send_beat(CMD_SHR, Q31_MIN, $urandom(), $urandom(), 6'd31);
  endtask

  task automatic test_unused_codes();
    send_beat(CMD_UNUSED_HI, $urandom(), $urandom(), $urandom(), rand_shift());
  endtask

  task automatic test_random_mix(input int count);
    logic [3:0] op;
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) op = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else op = 4'($urandom_range(CMD_ADD, CMD_SHR));
      send_beat(op, rand_q31(), rand_q31(), rand_q31(), rand_shift());
    end
  endtask

  // Mostly dividends below the divisor, so the bisection is exercised.
  task automatic test_random_divide(input int count);
    logic signed [Q31_W-1:0] a, b;
    longint                  mag_b, mag_a;
    repeat (count) begin
      b = rand_q31();
      a = rand_q31();
      if (b != 0 && $urandom_range(0, 4) != 0) begin
        mag_b = (b < 0) ? -longint'(b) : longint'(b);
        mag_a = longint'($urandom()) % mag_b;
        a     = 32'($urandom_range(0, 1) ? -mag_a : mag_a);
      end
      send_beat(CMD_DIV, a, b, $urandom(), rand_shift());
    end
  endtask

  // Back-to-back beats with no gaps and no output stalls.
  task automatic test_random_no_idle(input int count);
    idle_off = 1'b1;
    test_random_mix(count);
    idle_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    #1 rst_n = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    test_add_sub();
    test_multiply();
    test_abs();
    test_divide();
    test_shifts();
    test_unused_codes();
    test_random_mix(600);
    test_random_divide(200);
    test_random_no_idle(150);

    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input beats over all command codes, rails, divide and shift corners;",
             beats_sent);
    $display("%0d results checked with random gaps, stalls and gap-free bursts, %0d failures.",
             results_checked, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
